// ===== rtl/core/i2cmbe_pkg.sv =====
// shared types and constants for the i2c master byte engine
package i2cmbe_pkg;

   localparam int unsigned LOOPS_PER_DELAY_DEFAULT = 10;
   localparam logic [15:0] HALF_BIT_DELAY_RESET    = 16'd10;
   localparam int unsigned PHASE_W                 = 5;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_STOP  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

endpackage

// ===== rtl/core/i2c_master_byte_engine_unit.sv =====
// i2c master byte engine: turns one command into a run of pin phases
// sequence: idle takes the command, each phase is built in ST_LOAD and offered in ST_EMIT,
// and a phase with its wait flag set is then held in ST_DELAY before the next phase or idle
// hold: set by half_bit_delay and LOOPS_PER_DELAY, counted down by the shared tick and loop counters
// a command is 3 (start), 4 (stop), 19 (write) or 21/22 (read) phases; req_ready only in idle
// reset (synchronous): idle, scl low, sda low and driven, half_bit_delay = 10
module i2c_master_byte_engine_unit #(
   parameter int unsigned LOOPS_PER_DELAY = i2cmbe_pkg::LOOPS_PER_DELAY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic [7:0]  req_target_byte,
   input  logic        req_target_ack_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_driven,
   output logic        rsp_wait_after,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_error,
   output logic        rsp_last_phase
);
   import i2cmbe_pkg::*;

   localparam int unsigned LOOP_W = (LOOPS_PER_DELAY > 1) ? $clog2(LOOPS_PER_DELAY) : 1;
   localparam logic [LOOP_W-1:0] LOOP_LAST = LOOP_W'(LOOPS_PER_DELAY - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT,
      ST_DELAY
   } state_type;

   state_type          state_ff, state_in;
   action_type         act_ff, act_in;
   logic [7:0]         tx_ff, tx_in;
   logic               sack_ff, sack_in;
   logic [7:0]         tb_ff, tb_in;
   logic               tal_ff, tal_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               clk_line_ff, clk_line_in;
   logic               dat_line_ff, dat_line_in;
   logic               dir_ff, dir_in;
   logic [15:0]        delay_ff, delay_in;
   logic [15:0]        tick_ff, tick_in;
   logic [LOOP_W-1:0]  loop_ff, loop_in;
   logic               valid_ff, valid_in;
   logic               wait_ff, wait_in;
   logic               last_ff, last_in;
   logic [7:0]         rx_ff, rx_in;
   logic               err_ff, err_in;

   logic               gen_clk, gen_dat, gen_dir, gen_wait, gen_last, gen_err;
   logic [7:0]         gen_rx;

   // phase generator
   always_comb begin
      gen_clk  = clk_line_ff;
      gen_dat  = dat_line_ff;
      gen_dir  = dir_ff;
      gen_wait = 1'b1;
      gen_last = 1'b0;
      gen_err  = 1'b0;
      gen_rx   = '0;
      unique case (act_ff)
         ACT_START: begin
            priority if (phase_ff == PHASE_W'(0)) begin
               gen_dir = 1'b1;
               gen_dat = 1'b1;
               gen_clk = 1'b1;
            end else if (phase_ff == PHASE_W'(1)) begin
               gen_dat = 1'b0;
            end else begin
               gen_clk  = 1'b0;
               gen_last = 1'b1;
            end
         end
         ACT_STOP: begin
            priority if (phase_ff == PHASE_W'(0)) begin
               gen_dir = 1'b1;
               gen_clk = 1'b0;
            end else if (phase_ff == PHASE_W'(1)) begin
               gen_dat = 1'b0;
            end else if (phase_ff == PHASE_W'(2)) begin
               gen_clk = 1'b1;
            end else begin
               gen_dat  = 1'b1;
               gen_last = 1'b1;
            end
         end
         ACT_WRITE: begin
            priority if (phase_ff < PHASE_W'(16)) begin
               if (!phase_ff[0]) begin
                  if (phase_ff[3:1] == 3'd0) begin
                     gen_dir = 1'b1;
                  end else begin
                     gen_clk = 1'b0;
                  end
                  gen_dat = tx_ff[3'd7 - phase_ff[3:1]];
               end else begin
                  gen_clk = 1'b1;
               end
            end else if (phase_ff == PHASE_W'(16)) begin
               gen_clk = 1'b0;
               gen_dir = 1'b0;
            end else if (phase_ff == PHASE_W'(17)) begin
               gen_clk = 1'b1;
            end else begin
               gen_clk  = 1'b0;
               gen_wait = 1'b0;
               gen_last = 1'b1;
               gen_err  = tal_ff;
            end
         end
         ACT_READ: begin
            priority if (phase_ff == PHASE_W'(0)) begin
               gen_dat  = 1'b1;
               gen_clk  = 1'b0;
               gen_dir  = 1'b0;
               gen_wait = 1'b0;
            end else if (phase_ff <= PHASE_W'(16)) begin
               gen_clk = phase_ff[0];
            end else if (phase_ff == PHASE_W'(17)) begin
               gen_dir = 1'b1;
               gen_clk = 1'b0;
            end else if (phase_ff == PHASE_W'(18)) begin
               gen_dat = !sack_ff;
            end else if (phase_ff == PHASE_W'(19)) begin
               gen_clk = 1'b1;
            end else if (phase_ff == PHASE_W'(20)) begin
               gen_clk  = 1'b0;
               gen_last = !sack_ff;
               gen_rx   = sack_ff ? 8'd0 : tb_ff;
            end else begin
               gen_dat  = 1'b1;
               gen_wait = 1'b0;
               gen_last = 1'b1;
               gen_rx   = tb_ff;
            end
         end
         default: begin
            gen_last = 1'b1;
         end
      endcase
   end

   // sequencer and shared delay counter
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      tx_in       = tx_ff;
      sack_in     = sack_ff;
      tb_in       = tb_ff;
      tal_in      = tal_ff;
      phase_in    = phase_ff;
      clk_line_in = clk_line_ff;
      dat_line_in = dat_line_ff;
      dir_in      = dir_ff;
      delay_in    = csr_write_enable ? csr_write_data : delay_ff;
      tick_in     = tick_ff;
      loop_in     = loop_ff;
      valid_in    = valid_ff;
      wait_in     = wait_ff;
      last_in     = last_ff;
      rx_in       = rx_ff;
      err_in      = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               tx_in    = req_tx_byte;
               sack_in  = req_send_ack;
               tb_in    = req_target_byte;
               tal_in   = req_target_ack_level;
               phase_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            clk_line_in = gen_clk;
            dat_line_in = gen_dat;
            dir_in      = gen_dir;
            wait_in     = gen_wait;
            last_in     = gen_last;
            rx_in       = gen_rx;
            err_in      = gen_err;
            valid_in    = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               priority if (wait_ff) begin
                  tick_in  = delay_ff;
                  loop_in  = LOOP_LAST;
                  state_in = ST_DELAY;
               end else if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_ff + PHASE_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DELAY: begin
            priority if (tick_ff == 16'd0) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_ff + PHASE_W'(1);
                  state_in = ST_LOAD;
               end
            end else if (loop_ff == '0) begin
               tick_in = tick_ff - 16'd1;
               loop_in = LOOP_LAST;
            end else begin
               loop_in = loop_ff - LOOP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         clk_line_ff <= 1'b0;
         dat_line_ff <= 1'b0;
         dir_ff      <= 1'b1;
         delay_ff    <= HALF_BIT_DELAY_RESET;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clk_line_ff <= clk_line_in;
         dat_line_ff <= dat_line_in;
         dir_ff      <= dir_in;
         delay_ff    <= delay_in;
         valid_ff    <= valid_in;
      end
      act_ff   <= act_in;
      tx_ff    <= tx_in;
      sack_ff  <= sack_in;
      tb_ff    <= tb_in;
      tal_ff   <= tal_in;
      phase_ff <= phase_in;
      tick_ff  <= tick_in;
      loop_ff  <= loop_in;
      wait_ff  <= wait_in;
      last_ff  <= last_in;
      rx_ff    <= rx_in;
      err_ff   <= err_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_scl_level  = clk_line_ff;
   assign rsp_sda_level  = dat_line_ff;
   assign rsp_sda_driven = dir_ff;
   assign rsp_wait_after = wait_ff;
   assign rsp_rx_byte    = rx_ff;
   assign rsp_ack_error  = err_ff;
   assign rsp_last_phase = last_ff;

   // no new command while a phase is pending
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !rsp_valid)
      else $error("command transfer possible while a phase is pending");

   // a final phase without hold returns straight to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_phase && !rsp_wait_after |=> req_ready)
      else $error("engine not idle after final phase");

   // received byte and ack error only on the final phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_phase |-> rsp_rx_byte == 8'd0 && !rsp_ack_error)
      else $error("status fields set before final phase");

   // ack error only reported while sda is released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_error |-> !rsp_sda_driven)
      else $error("ack error reported while sda driven");

endmodule
